FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of the stream buffer prefetcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define SBP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("stream buffer prefetcher check failed");

// Condition that must never be true at a rising clock edge outside reset.
`define SBP_ASSERT_NEVER(label, clk, rst_n, cond) \
  `SBP_ASSERT(label, clk, rst_n, !(cond))

`endif

FILE: sv/sbp_pkg.sv
// Shared types and constants of the stream buffer prefetcher.
package sbp_pkg;

  // Default geometry of the stream buffers.
  localparam int NUM_ROWS_DEF  = 4;
  localparam int ROW_DEPTH_DEF = 4;

  // Field and bus widths.
  localparam int ADDR_W      = 32;
  localparam int ACTION_W    = 2;
  localparam int OUT_TDATA_W = 8;

  // Action codes; every other code probes only.
  localparam logic [ACTION_W-1:0] ACT_MISS = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_HIT  = 2'd2;

  // Narrow result fields.
  typedef logic [1:0] row_field_t;
  typedef logic [1:0] col_field_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    row_field_t alloc_row;
    logic       allocated;
    col_field_t hit_col;
    row_field_t hit_row;
    logic       hit;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming item
    logic commit;  // update the rows and the result register
  } ctrl_cmd_t;

endpackage

FILE: sv/sbp_ctrl.sv
// Controller of the stream buffer prefetcher: handshakes and sequencing.
module sbp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output sbp_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   m_tvalid_q, m_tvalid_d;
  logic   accept;
  logic   commit;

  // An item is taken in idle and executed once the result register is free.
  assign accept = (state_q == S_IDLE) && s_tvalid_i;
  assign commit = (state_q == S_EXEC) && (!m_tvalid_q || m_tready_i);

  always_comb begin
    state_d    = state_q;
    m_tvalid_d = m_tvalid_q;
    if (m_tready_i) begin
      m_tvalid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_d    = S_IDLE;
          m_tvalid_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  assign s_tready_o   = (state_q == S_IDLE);
  assign m_tvalid_o   = m_tvalid_q;
  assign cmd_o.load   = accept;
  assign cmd_o.commit = commit;

endmodule

FILE: sv/sbp_dpath.sv
// Datapath of the stream buffer prefetcher: row state, compares and updates.
module sbp_dpath #(
  parameter int NUM_ROWS  = sbp_pkg::NUM_ROWS_DEF,
  parameter int ROW_DEPTH = sbp_pkg::ROW_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sbp_pkg::ctrl_cmd_t            cmd_i,
  input  logic [sbp_pkg::ACTION_W-1:0]  action_i,
  input  logic [sbp_pkg::ADDR_W-1:0]    addr_i,
  output sbp_pkg::result_t              result_o
);

  localparam int RowW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int AgeW = RowW;
  localparam logic [sbp_pkg::ADDR_W-1:0] Depth = sbp_pkg::ADDR_W'(ROW_DEPTH);

  // Row state.
  logic [NUM_ROWS-1:0]       valid_q;
  logic [AgeW-1:0]           age_q  [NUM_ROWS];
  logic [sbp_pkg::ADDR_W-1:0] head_q [NUM_ROWS];

  // Captured item and result register.
  logic [sbp_pkg::ACTION_W-1:0] action_q;
  logic [sbp_pkg::ADDR_W-1:0]   addr_q;
  sbp_pkg::result_t             res_q, res_d;

  // Compare and selection signals.
  logic [sbp_pkg::ADDR_W-1:0] off [NUM_ROWS];
  logic [NUM_ROWS-1:0]        match, win, oldest;
  logic [RowW-1:0]            win_idx, old_idx, free_idx, alloc_idx;
  logic [AgeW-1:0]            win_age;
  sbp_pkg::col_field_t        win_col;
  logic                       any_hit, any_free, do_restart, do_alloc;

  // Offset of the address into each row and the per-row match.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      off[r]   = addr_q - head_q[r];
      match[r] = valid_q[r] && (off[r] < Depth);
    end
  end

  // Pairwise age compares: youngest matching row, and oldest row (last on ties).
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      win[r]    = match[r];
      oldest[r] = 1'b1;
      for (int s = 0; s < NUM_ROWS; s++) begin
        if (s != r) begin
          if (match[s] && ((age_q[s] < age_q[r]) || ((age_q[s] == age_q[r]) && (s < r)))) begin
            win[r] = 1'b0;
          end
          if (!((age_q[s] < age_q[r]) || ((age_q[s] == age_q[r]) && (s < r)))) begin
            oldest[r] = 1'b0;
          end
        end
      end
    end
  end

  // Encode the one-hot selections.
  always_comb begin
    win_idx = '0;
    win_age = '0;
    win_col = '0;
    old_idx = '0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (win[r]) begin
        win_idx = win_idx | RowW'(r);
        win_age = win_age | age_q[r];
        win_col = win_col | off[r][1:0];
      end
      if (oldest[r]) begin
        old_idx = old_idx | RowW'(r);
      end
    end
  end

  // First invalid row.
  always_comb begin
    free_idx = '0;
    for (int r = NUM_ROWS - 1; r >= 0; r--) begin
      if (!valid_q[r]) begin
        free_idx = RowW'(r);
      end
    end
  end

  assign any_hit    = |match;
  assign any_free   = ~&valid_q;
  assign alloc_idx  = any_free ? free_idx : old_idx;
  assign do_restart = any_hit && ((action_q == sbp_pkg::ACT_MISS) ||
                                  (action_q == sbp_pkg::ACT_HIT));
  assign do_alloc   = !any_hit && (action_q == sbp_pkg::ACT_MISS);

  // Result of the current item.
  always_comb begin
    res_d.hit       = any_hit;
    res_d.hit_row   = sbp_pkg::row_field_t'(win_idx);
    res_d.hit_col   = win_col;
    res_d.allocated = do_alloc;
    res_d.alloc_row = do_alloc ? sbp_pkg::row_field_t'(alloc_idx) : '0;
  end

  // Valid bits and recency counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int r = 0; r < NUM_ROWS; r++) begin
        age_q[r] <= '0;
      end
    end else if (cmd_i.commit) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        if (do_restart) begin
          if (RowW'(r) == win_idx) begin
            age_q[r] <= '0;
          end else if (valid_q[r] && (age_q[r] < win_age)) begin
            age_q[r] <= age_q[r] + AgeW'(1);
          end
        end else if (do_alloc) begin
          if (RowW'(r) == alloc_idx) begin
            valid_q[r] <= 1'b1;
            age_q[r]   <= '0;
          end else if (valid_q[r]) begin
            age_q[r] <= age_q[r] + AgeW'(1);
          end
        end
      end
    end
  end

  // Head addresses: a restarted or filled row begins just past the address.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        if ((do_restart && (RowW'(r) == win_idx)) || (do_alloc && (RowW'(r) == alloc_idx))) begin
          head_q[r] <= addr_q + sbp_pkg::ADDR_W'(1);
        end
      end
    end
  end

  // Item capture and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      addr_q   <= addr_i;
    end
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

FILE: sv/stream_buffer_prefetcher.sv
// Stream buffer prefetcher: each item is first transferred in and then handled in an
// execute cycle in which all rows are compared at once, the youngest matching row or the
// allocation target is chosen, and the recency counts, head addresses and result register
// are updated together. The execute cycle waits while an earlier result is still not
// taken, so a stalled output holds the item; a new item is taken only after it executes.
module stream_buffer_prefetcher #(
  parameter int NUM_ROWS  = sbp_pkg::NUM_ROWS_DEF,
  parameter int ROW_DEPTH = sbp_pkg::ROW_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sbp_pkg::ADDR_W-1:0]      s_axis_tdata,  // [31:0] line address
  input  logic [sbp_pkg::ACTION_W-1:0]    s_axis_tuser,  // [1:0] action
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] hit, [2:1] hit_row, [4:3] hit_col, [5] allocated, [7:6] alloc_row
  output logic [sbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  sbp_pkg::ctrl_cmd_t cmd;
  sbp_pkg::result_t   result;

  sbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd)
  );

  sbp_dpath #(
    .NUM_ROWS  (NUM_ROWS),
    .ROW_DEPTH (ROW_DEPTH)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .action_i (s_axis_tuser),
    .addr_i   (s_axis_tdata),
    .result_o (result)
  );

  assign m_axis_tdata = result;

endmodule

FILE: sv/sbp_checker.sv
// Port-level checks of the stream buffer prefetcher and their binding.
`include "assert_macros.svh"

module sbp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  sbp_pkg::result_t res;

  assign res = m_axis_tdata;

  // One item at a time: no transfer in right after one was taken.
  `SBP_ASSERT(a_one_in_flight, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)

  // A waiting result holds its value.
  `SBP_ASSERT(a_result_holds, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

  // Without a hit the hit position reads as zero.
  `SBP_ASSERT_NEVER(a_no_hit_pos, clk_i, rst_ni, m_axis_tvalid && !res.hit && ((res.hit_row != 2'd0) || (res.hit_col != 2'd0)))

  // A hit never allocates, and no allocation names a row.
  `SBP_ASSERT_NEVER(a_alloc_excl, clk_i, rst_ni, m_axis_tvalid && ((res.hit && res.allocated) || (!res.allocated && (res.alloc_row != 2'd0))))

endmodule

bind stream_buffer_prefetcher sbp_checker u_sbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/testbench.sv
// Self-checking testbench of the stream buffer prefetcher with random flow control.

// Tracks the rows the block should hold and the lookup results it should return.
class prefetch_scoreboard;
  bit                         row_valid [sbp_pkg::NUM_ROWS_DEF];
  logic [7:0]                 row_age   [sbp_pkg::NUM_ROWS_DEF];
  logic [sbp_pkg::ADDR_W-1:0] row_head  [sbp_pkg::NUM_ROWS_DEF];
  sbp_pkg::result_t           lookup_q  [$];
  int                         mismatches;

  function new();
    mismatches = 0;
    for (int r = 0; r < sbp_pkg::NUM_ROWS_DEF; r++) begin
      row_valid[r] = 1'b0;
      row_age[r]   = '0;
      row_head[r]  = '0;
    end
  endfunction

  // Ages saturate at the top of their range.
  function void age_up(int r);
    if (row_age[r] != 8'hff) row_age[r]++;
  endfunction

  // Looks up one address, applies the action to the rows and returns the result.
  function sbp_pkg::result_t lookup_and_update(logic [sbp_pkg::ACTION_W-1:0] action,
                                               logic [sbp_pkg::ADDR_W-1:0] addr);
    sbp_pkg::result_t           res;
    logic [sbp_pkg::ADDR_W-1:0] offset;
    int                         best;
    int                         own;
    int                         target;
    int                         oldest;
    res  = '0;
    best = 256;
    // The youngest matching row wins; ties keep the lowest row.
    for (int r = 0; r < sbp_pkg::NUM_ROWS_DEF; r++) begin
      offset = addr - row_head[r];
      if (row_valid[r] && offset < sbp_pkg::ROW_DEPTH_DEF && row_age[r] < best) begin
        best        = row_age[r];
        res.hit     = 1'b1;
        res.hit_row = sbp_pkg::row_field_t'(r);
        res.hit_col = sbp_pkg::col_field_t'(offset);
      end
    end
    if (res.hit && (action == sbp_pkg::ACT_MISS || action == sbp_pkg::ACT_HIT)) begin
      // Restart the matching row just past the address and make it newest.
      own = row_age[res.hit_row];
      for (int r = 0; r < sbp_pkg::NUM_ROWS_DEF; r++)
        if (r != res.hit_row && row_valid[r] && row_age[r] < own) age_up(r);
      row_age[res.hit_row]  = '0;
      row_head[res.hit_row] = addr + 1;
    end else if (!res.hit && action == sbp_pkg::ACT_MISS) begin
      // Fill the first free row, else the oldest one with the highest index on ties.
      target = -1;
      for (int r = 0; r < sbp_pkg::NUM_ROWS_DEF; r++)
        if (!row_valid[r] && target < 0) target = r;
      if (target < 0) begin
        oldest = 0;
        for (int r = 0; r < sbp_pkg::NUM_ROWS_DEF; r++)
          if (row_age[r] >= oldest) begin
            oldest = row_age[r];
            target = r;
          end
      end
      for (int r = 0; r < sbp_pkg::NUM_ROWS_DEF; r++)
        if (row_valid[r]) age_up(r);
      row_valid[target] = 1'b1;
      row_age[target]   = '0;
      row_head[target]  = addr + 1;
      res.allocated     = 1'b1;
      res.alloc_row     = sbp_pkg::row_field_t'(target);
    end
    return res;
  endfunction

  function void note_input(logic [sbp_pkg::ACTION_W-1:0] action,
                           logic [sbp_pkg::ADDR_W-1:0] addr);
    lookup_q.push_back(lookup_and_update(action, addr));
  endfunction

  task report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 40)
      $display("MISMATCH %s: got %0d, predicted %0d", what, got, want);
  endtask

  task check_result(sbp_pkg::result_t got);
    sbp_pkg::result_t want;
    if (lookup_q.size() == 0) begin
      report_mismatch("result with no lookup outstanding", got, 0);
      return;
    end
    want = lookup_q.pop_front();
    if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
    if (got.hit_row !== want.hit_row) report_mismatch("hit_row", got.hit_row, want.hit_row);
    if (got.hit_col !== want.hit_col) report_mismatch("hit_col", got.hit_col, want.hit_col);
    if (got.allocated !== want.allocated)
      report_mismatch("allocated", got.allocated, want.allocated);
    if (got.alloc_row !== want.alloc_row)
      report_mismatch("alloc_row", got.alloc_row, want.alloc_row);
  endtask

  function int outstanding();
    return lookup_q.size();
  endfunction
endclass

module testbench;

  // Action codes not named in the package.
  localparam logic [sbp_pkg::ACTION_W-1:0] ACT_PROBE = 2'd0;
  localparam logic [sbp_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;

  localparam int RANDOM_ITEMS   = 1800;
  localparam int HOLD_AT        = 700;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DIRECTED_ITEMS = 21;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_e;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [sbp_pkg::ADDR_W-1:0]      s_axis_tdata;
  logic [sbp_pkg::ACTION_W-1:0]    s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [sbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  prefetch_scoreboard sb = new();
  int inputs_accepted = 0;
  int idle_cycles     = 0;

  // Directed lookups: empty rows, wrap at the top of the address space, overlapping rows,
  // replacement of the oldest row, the unused action code and a hit access with no match.
  logic [sbp_pkg::ACTION_W-1:0] dir_act [DIRECTED_ITEMS] = '{
    ACT_PROBE, sbp_pkg::ACT_HIT, sbp_pkg::ACT_MISS, ACT_PROBE, ACT_SPARE, ACT_PROBE,
    sbp_pkg::ACT_HIT, sbp_pkg::ACT_MISS, ACT_PROBE, ACT_PROBE, sbp_pkg::ACT_MISS,
    sbp_pkg::ACT_MISS, ACT_PROBE, sbp_pkg::ACT_MISS, sbp_pkg::ACT_MISS, sbp_pkg::ACT_HIT,
    sbp_pkg::ACT_MISS, ACT_SPARE, sbp_pkg::ACT_MISS, ACT_PROBE, sbp_pkg::ACT_HIT};
  logic [sbp_pkg::ADDR_W-1:0] dir_addr [DIRECTED_ITEMS] = '{
    32'h0000_0000, 32'h1234_5678, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0003,
    32'h0000_0004, 32'h0000_0002, 32'hffff_fffd, 32'hffff_ffff, 32'h0000_0001,
    32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001, 32'h5555_5555, 32'haaaa_aaaa,
    32'h5555_5557, 32'haaaa_aaab, 32'h0f0f_0f0f, 32'h0000_0000, 32'hffff_ffff,
    32'hffff_ffff};

  stream_buffer_prefetcher uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offers one lookup and returns at the edge where it transfers.
  task automatic send_item(logic [sbp_pkg::ACTION_W-1:0] action,
                           logic [sbp_pkg::ADDR_W-1:0] addr);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= action;
    s_axis_tdata  <= addr;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle(int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stops offering until every outstanding result has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic logic [sbp_pkg::ACTION_W-1:0] pick_action();
    int n;
    n = $urandom_range(0, 19);
    if (n < 8) return sbp_pkg::ACT_MISS;
    if (n < 14) return sbp_pkg::ACT_HIT;
    if (n < 19) return ACT_PROBE;
    return ACT_SPARE;
  endfunction

  // Mostly addresses in or next to the current rows or continuing the last stream.
  function automatic logic [sbp_pkg::ADDR_W-1:0] pick_addr(logic [sbp_pkg::ADDR_W-1:0] prev);
    int sel;
    int r;
    sel = $urandom_range(0, 9);
    r   = $urandom_range(0, sbp_pkg::NUM_ROWS_DEF - 1);
    if (sel < 4 && sb.row_valid[r]) return sb.row_head[r] + $urandom_range(0, 5) - 1;
    if (sel < 7) return prev + 1;
    if (sel == 7) return 32'hffff_ffff - $urandom_range(0, 6);
    if (sel == 8) return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h0} + $urandom_range(0, 3);
    return $urandom();
  endfunction

  // Main stimulus sequence.
  initial begin
    int sent;
    int burst;
    logic [sbp_pkg::ADDR_W-1:0] addr;
    logic [sbp_pkg::ADDR_W-1:0] prev;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_PROBE;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_ITEMS; i++) begin
      send_item(dir_act[i], dir_addr[i]);
      if ($urandom_range(0, 2) == 0) idle($urandom_range(1, 3));
    end
    drain_results();

    // Random bursts with gaps; some stretches run with no gaps at all.
    sent = 0;
    prev = $urandom();
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        addr = pick_addr(prev);
        send_item(pick_action(), addr);
        prev = addr;
        sent++;
        if (sent == RANDOM_ITEMS / 2) drain_results();
      end
      if ((sent % 600) >= 150 && $urandom_range(0, 2) != 0) idle($urandom_range(1, 8));
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side ready pattern, with one long hold-off that fills the block.
  initial begin
    int seg;
    int cnt;
    rx_mode_e mode;
    bit held;
    held = 1'b0;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && inputs_accepted >= HOLD_AT) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        held = 1'b1;
      end
      seg  = $urandom_range(20, 200);
      mode = rx_mode_e'($urandom_range(0, 3));
      for (cnt = 0; cnt < seg; cnt++) begin
        case (mode)
          RX_ALWAYS:   m_axis_tready <= 1'b1;
          RX_COIN:     m_axis_tready <= $urandom_range(0, 1) != 0;
          RX_MOSTLY:   m_axis_tready <= $urandom_range(0, 3) != 0;
          RX_PERIODIC: m_axis_tready <= (cnt % 8) < 5;
          default:     m_axis_tready <= 1'b1;
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Transfer monitor and watchdog; results are checked before the new lookup is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(sbp_pkg::result_t'(m_axis_tdata));
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_input(s_axis_tuser, s_axis_tdata);
        inputs_accepted++;
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule

FILE: sim.f
+incdir+sv
sv/sbp_pkg.sv
sv/sbp_ctrl.sv
sv/sbp_dpath.sv
sv/stream_buffer_prefetcher.sv
sv/sbp_checker.sv
verif/testbench.sv
